// ===== sv/rhcl_pkg.sv =====
// Shared constants, types and elaboration-time helpers for the RGB to hue/chroma/lightness block.
package rhcl_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned HUE_FRAC_DEF    = 13;

  // Hue result port width (Q3.13 by default, masked to 16 bits).
  localparam int unsigned HUE_W      = 16;
  // Ratio t/chroma carries 28 fraction bits; t < 6*chroma so 31 quotient bits.
  localparam int unsigned RATIO_BITS = 28;
  localparam int unsigned QUO_W      = RATIO_BITS + 3;
  // round(pi/3 * 2^32) = 2^32 + PI3_LO
  localparam logic [63:0] PI3_Q32    = 64'd4497679235;
  localparam int unsigned PI3_LO_W   = 28;
  localparam logic [PI3_LO_W-1:0] PI3_LO = PI3_LO_W'(PI3_Q32 - 64'h1_0000_0000);
  localparam int unsigned PROD_W     = 64;

  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2
  } max_sel_e;

  // Scaled value of a full turn (ratio 6.0); a hue that rounds to it wraps to 0.
  function automatic logic [63:0] hue_full(input int unsigned frac);
    logic [63:0] prod;
    int unsigned shift;
    shift = RATIO_BITS + 32 - frac;
    prod  = (64'd6 << RATIO_BITS) * PI3_Q32;
    return (prod + (64'd1 << (shift - 1))) >> shift;
  endfunction

endpackage

// ===== sv/rgb_to_hue_chroma_lightness_top.sv =====
// Top level: RGB to hue / chroma / lightness pipeline with output skid buffer.
//
// Usage:
//  - Input channel: one request is red_i/green_i/blue_i, taken at a rising edge
//    with in_valid_i high and in_stall_o low.
//  - Output channel: one request is hue_o/chroma_o/lightness_o/gray_o, taken at
//    a rising edge with out_valid_o high and out_stall_i low.
//  - Hue is radians in unsigned Q3.HUE_FRAC_BITS; gray pixels (chroma zero)
//    give hue 0 and gray_o high.
//  - Depth: 38 register stages (3 front stages, 31 division
//    stages at one quotient bit each, 3 scaling stages, output register).
//  - Throughput: one request per cycle while the skid register is empty; the
//    31-stage restoring divider sets the depth, each stage one compare and subtract.
//  - Reset clears all valid bits; payload registers are not reset.
//  - When the receiver stalls, the result held on the output is kept and the
//    next finished result drops into a one-entry skid register; only while
//    that skid is full does the whole pipeline freeze and in_stall_o rise.
//    in_stall_o comes straight from a flop.
module rgb_to_hue_chroma_lightness_top #(
  parameter int unsigned SAMPLE_BITS   = rhcl_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned HUE_FRAC_BITS = rhcl_pkg::HUE_FRAC_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [SAMPLE_BITS-1:0]     red_i,
  input  logic [SAMPLE_BITS-1:0]     green_i,
  input  logic [SAMPLE_BITS-1:0]     blue_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [rhcl_pkg::HUE_W-1:0] hue_o,
  output logic [SAMPLE_BITS-1:0]     chroma_o,
  output logic [SAMPLE_BITS-1:0]     lightness_o,
  output logic                       gray_o
);
  import rhcl_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;

  // Global advance: the pipeline moves whenever the skid register is empty.
  logic en;
  logic skid_valid_q, out_valid_q;

  assign en = !skid_valid_q;

  // ---- front end ----
  logic          f_valid, f_gray;
  logic [SB+2:0] f_t;
  logic [SB-1:0] f_chroma, f_light;

  rhcl_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .valid_o     (f_valid),
    .t_o         (f_t),
    .chroma_o    (f_chroma),
    .lightness_o (f_light),
    .gray_o      (f_gray)
  );

  // ---- divider chain: quotient = (t << 28) / chroma, one bit per stage ----
  // Starting remainder is t >> 3 (below chroma since t < 6*chroma); the three
  // low bits of t are shifted in by the first three stages, zeros after that.
  logic             dv_valid [QUO_W+1];
  logic [SB-1:0]    dv_rem   [QUO_W+1];
  logic [2:0]       dv_tlo   [QUO_W+1];
  logic [QUO_W-1:0] dv_quo   [QUO_W+1];
  logic [SB-1:0]    dv_c     [QUO_W+1];
  logic [SB-1:0]    dv_l     [QUO_W+1];
  logic             dv_gray  [QUO_W+1];

  assign dv_valid[0] = f_valid;
  assign dv_rem[0]   = f_t[SB+2:3];
  assign dv_tlo[0]   = f_t[2:0];
  assign dv_quo[0]   = '0;
  assign dv_c[0]     = f_chroma;
  assign dv_l[0]     = f_light;
  assign dv_gray[0]  = f_gray;

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    rhcl_div_step #(.SAMPLE_BITS(SAMPLE_BITS)) u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .valid_i     (dv_valid[i]),
      .rem_i       (dv_rem[i]),
      .tlo_i       (dv_tlo[i]),
      .quo_i       (dv_quo[i]),
      .chroma_i    (dv_c[i]),
      .lightness_i (dv_l[i]),
      .gray_i      (dv_gray[i]),
      .valid_o     (dv_valid[i+1]),
      .rem_o       (dv_rem[i+1]),
      .tlo_o       (dv_tlo[i+1]),
      .quo_o       (dv_quo[i+1]),
      .chroma_o    (dv_c[i+1]),
      .lightness_o (dv_l[i+1]),
      .gray_o      (dv_gray[i+1])
    );
  end

  // ---- scaling ----
  logic             p_valid, p_gray;
  logic [HUE_W-1:0] p_hue;
  logic [SB-1:0]    p_chroma, p_light;

  rhcl_scale #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (dv_valid[QUO_W]),
    .quo_i       (dv_quo[QUO_W]),
    .chroma_i    (dv_c[QUO_W]),
    .lightness_i (dv_l[QUO_W]),
    .gray_i      (dv_gray[QUO_W]),
    .valid_o     (p_valid),
    .hue_o       (p_hue),
    .chroma_o    (p_chroma),
    .lightness_o (p_light),
    .gray_o      (p_gray)
  );

  // ---- output register + skid ----
  logic             out_free;
  logic             load_out_pipe, load_out_skid, load_skid;
  logic [HUE_W-1:0] out_hue_q, skid_hue_q;
  logic [SB-1:0]    out_c_q, out_l_q, skid_c_q, skid_l_q;
  logic             out_gray_q, skid_gray_q;

  assign out_free      = !out_valid_q || !out_stall_i;
  assign load_out_skid = skid_valid_q && !out_stall_i;
  assign load_out_pipe = en && p_valid && out_free;
  assign load_skid     = en && p_valid && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (load_out_skid) begin
        skid_valid_q <= 1'b0;
      end else if (load_skid) begin
        skid_valid_q <= 1'b1;
      end
      if (load_out_skid || load_out_pipe) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_skid) begin
      out_hue_q  <= skid_hue_q;
      out_c_q    <= skid_c_q;
      out_l_q    <= skid_l_q;
      out_gray_q <= skid_gray_q;
    end else if (load_out_pipe) begin
      out_hue_q  <= p_hue;
      out_c_q    <= p_chroma;
      out_l_q    <= p_light;
      out_gray_q <= p_gray;
    end
    if (load_skid) begin
      skid_hue_q  <= p_hue;
      skid_c_q    <= p_chroma;
      skid_l_q    <= p_light;
      skid_gray_q <= p_gray;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign hue_o       = out_hue_q;
  assign chroma_o    = out_c_q;
  assign lightness_o = out_l_q;
  assign gray_o      = out_gray_q;

  // ---- assertions ----
  // skid only holds data behind a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid full while output empty");

  // skid fills only when the output was blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled without output stall");

  // gray result carries zero hue and zero chroma
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_gray_q) |-> (out_hue_q == '0 && out_c_q == '0))
    else $error("gray result with nonzero hue or chroma");

  // max-min never exceeds max+min: catches sideband misalignment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({1'b0, out_c_q} <= {out_l_q, 1'b1}))
    else $error("chroma exceeds lightness bound");

endmodule

// ===== sv/rhcl_front.sv =====
// Front stages: max/min search, chroma, lightness and the hue numerator t.
module rhcl_front #(
  parameter int unsigned SAMPLE_BITS = rhcl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [SAMPLE_BITS-1:0] red_i,
  input  logic [SAMPLE_BITS-1:0] green_i,
  input  logic [SAMPLE_BITS-1:0] blue_i,
  output logic                   valid_o,
  output logic [SAMPLE_BITS+2:0] t_o,
  output logic [SAMPLE_BITS-1:0] chroma_o,
  output logic [SAMPLE_BITS-1:0] lightness_o,
  output logic                   gray_o
);
  import rhcl_pkg::*;

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned T_W = SB + 3;

  // stage 1: max / min / winner
  logic          v1_q;
  logic [SB-1:0] r1_q, g1_q, b1_q, mx1_q, mn1_q;
  max_sel_e      sel1_q;
  logic [SB-1:0] mx_a, mn_a, mx_d, mn_d;
  max_sel_e      sel_a, sel_d;

  always_comb begin
    mx_a  = (green_i >= red_i) ? green_i : red_i;
    sel_a = (green_i >= red_i) ? SEL_GREEN : SEL_RED;
    mx_d  = (blue_i >= mx_a) ? blue_i : mx_a;
    sel_d = (blue_i >= mx_a) ? SEL_BLUE : sel_a;
    mn_a  = (green_i < red_i) ? green_i : red_i;
    mn_d  = (blue_i < mn_a) ? blue_i : mn_a;
  end

  // stage 2: chroma, lightness, signed difference of the other two channels
  logic                 v2_q;
  logic [SB-1:0]        c2_q, l2_q;
  logic signed [SB:0]   d2_q;
  logic [2:0]           k2_q;   // multiple of chroma to add: 0, 2, 4 or 6
  logic [SB:0]          sum2;
  logic signed [SB:0]   d2_d;
  logic [2:0]           k2_d;

  always_comb begin
    sum2 = {1'b0, mx1_q} + {1'b0, mn1_q};
    case (sel1_q)
      SEL_RED: begin
        d2_d = $signed({1'b0, g1_q}) - $signed({1'b0, b1_q});
        k2_d = d2_d[SB] ? 3'd6 : 3'd0;
      end
      SEL_GREEN: begin
        d2_d = $signed({1'b0, b1_q}) - $signed({1'b0, r1_q});
        k2_d = 3'd2;
      end
      SEL_BLUE: begin
        d2_d = $signed({1'b0, r1_q}) - $signed({1'b0, g1_q});
        k2_d = 3'd4;
      end
      default: begin
        d2_d = '0;
        k2_d = 3'd0;
      end
    endcase
  end

  // stage 3: t = k*chroma + d, lies in [0, 6*chroma)
  logic          v3_q, gray3_q;
  logic [T_W-1:0] t3_q;
  logic [SB-1:0] c3_q, l3_q;
  logic [T_W-1:0] kc, t3_d;

  always_comb begin
    kc   = (k2_q[2] ? (T_W'(c2_q) << 2) : '0) + (k2_q[1] ? (T_W'(c2_q) << 1) : '0);
    t3_d = kc + T_W'(d2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q    <= red_i;
      g1_q    <= green_i;
      b1_q    <= blue_i;
      mx1_q   <= mx_d;
      mn1_q   <= mn_d;
      sel1_q  <= sel_d;
      c2_q    <= mx1_q - mn1_q;
      l2_q    <= sum2[SB:1];
      d2_q    <= d2_d;
      k2_q    <= k2_d;
      t3_q    <= t3_d;
      c3_q    <= c2_q;
      l3_q    <= l2_q;
      gray3_q <= (c2_q == '0);
    end
  end

  assign valid_o     = v3_q;
  assign t_o         = t3_q;
  assign chroma_o    = c3_q;
  assign lightness_o = l3_q;
  assign gray_o      = gray3_q;

endmodule

// ===== sv/rhcl_div_step.sv =====
// One restoring-division stage: produces one quotient bit of t*2^28 / chroma.
module rhcl_div_step #(
  parameter int unsigned SAMPLE_BITS = rhcl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [SAMPLE_BITS-1:0]        rem_i,
  input  logic [2:0]                    tlo_i,
  input  logic [rhcl_pkg::QUO_W-1:0]    quo_i,
  input  logic [SAMPLE_BITS-1:0]        chroma_i,
  input  logic [SAMPLE_BITS-1:0]        lightness_i,
  input  logic                          gray_i,
  output logic                          valid_o,
  output logic [SAMPLE_BITS-1:0]        rem_o,
  output logic [2:0]                    tlo_o,
  output logic [rhcl_pkg::QUO_W-1:0]    quo_o,
  output logic [SAMPLE_BITS-1:0]        chroma_o,
  output logic [SAMPLE_BITS-1:0]        lightness_o,
  output logic                          gray_o
);
  import rhcl_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;

  logic          valid_q, gray_q, ge;
  logic [SB:0]   cand, diff;
  logic [SB-1:0] rem_q, chroma_q, light_q;
  logic [2:0]    tlo_q;
  logic [QUO_W-1:0] quo_q;

  always_comb begin
    cand = {rem_i, tlo_i[2]};
    diff = cand - {1'b0, chroma_i};
    ge   = (cand >= {1'b0, chroma_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q    <= ge ? diff[SB-1:0] : cand[SB-1:0];
      quo_q    <= {quo_i[QUO_W-2:0], ge};
      tlo_q    <= {tlo_i[1:0], 1'b0};
      chroma_q <= chroma_i;
      light_q  <= lightness_i;
      gray_q   <= gray_i;
    end
  end

  assign valid_o     = valid_q;
  assign rem_o       = rem_q;
  assign tlo_o       = tlo_q;
  assign quo_o       = quo_q;
  assign chroma_o    = chroma_q;
  assign lightness_o = light_q;
  assign gray_o      = gray_q;

endmodule

// ===== sv/rhcl_scale.sv =====
// Scaling stages: ratio times pi/3 with rounding, full-turn wrap and gray override.
module rhcl_scale #(
  parameter int unsigned SAMPLE_BITS   = rhcl_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned HUE_FRAC_BITS = rhcl_pkg::HUE_FRAC_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [rhcl_pkg::QUO_W-1:0]    quo_i,
  input  logic [SAMPLE_BITS-1:0]        chroma_i,
  input  logic [SAMPLE_BITS-1:0]        lightness_i,
  input  logic                          gray_i,
  output logic                          valid_o,
  output logic [rhcl_pkg::HUE_W-1:0]    hue_o,
  output logic [SAMPLE_BITS-1:0]        chroma_o,
  output logic [SAMPLE_BITS-1:0]        lightness_o,
  output logic                          gray_o
);
  import rhcl_pkg::*;

  localparam int unsigned SB        = SAMPLE_BITS;
  localparam int unsigned SHIFT     = RATIO_BITS + 32 - HUE_FRAC_BITS;
  localparam int unsigned HUE_INT_W = HUE_FRAC_BITS + 3;
  localparam int unsigned EXT_W     = HUE_INT_W + HUE_W;
  localparam logic [PROD_W-1:0]    HALF     = PROD_W'(64'd1 << (SHIFT - 1));
  localparam logic [HUE_INT_W-1:0] HUE_FULL = HUE_INT_W'(hue_full(HUE_FRAC_BITS));

  logic [2:0]       v_q, gray_q;
  logic [SB-1:0]    c_q   [3];
  logic [SB-1:0]    l_q   [3];
  logic [QUO_W-1:0] quo1_q, quo2_q;
  logic [PROD_W-1:0] prod1_q, acc2_q, sum3;
  logic [HUE_INT_W-1:0] hue3_q;
  logic [EXT_W-1:0] hue_ext;

  // low partial product only; the 2^32 part of pi/3 is added as a shift
  assign sum3 = acc2_q + (PROD_W'(quo2_q) << 32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= PROD_W'(quo_i) * PROD_W'(PI3_LO);
      quo1_q  <= quo_i;
      acc2_q  <= prod1_q + HALF;
      quo2_q  <= quo1_q;
      hue3_q  <= sum3[SHIFT +: HUE_INT_W];
      gray_q  <= {gray_q[1:0], gray_i};
      c_q[0]  <= chroma_i;
      c_q[1]  <= c_q[0];
      c_q[2]  <= c_q[1];
      l_q[0]  <= lightness_i;
      l_q[1]  <= l_q[0];
      l_q[2]  <= l_q[1];
    end
  end

  always_comb begin
    hue_ext = EXT_W'(hue3_q);
    if (gray_q[2] || (hue3_q >= HUE_FULL)) begin
      hue_ext = '0;
    end
  end

  assign valid_o     = v_q[2];
  assign hue_o       = hue_ext[HUE_W-1:0];
  assign chroma_o    = c_q[2];
  assign lightness_o = l_q[2];
  assign gray_o      = gray_q[2];

endmodule
